FILE: rtl/rme_pkg.sv
// ----------------------------------------------------------------------------
// rme_pkg
// Shared codes and constants of the register-mapped modular exponentiation
// engine: bus action codes, address map pages, key register codes, buffer targets and payload widths.
// ----------------------------------------------------------------------------
package rme_pkg;

  // payload widths
  localparam int DATA_W     = 32;
  localparam int IN_TDATA_W = 48;

  // bus action codes
  localparam logic [1:0] ACT_RD_BYTE = 2'd0;
  localparam logic [1:0] ACT_RD_WORD = 2'd1;
  localparam logic [1:0] ACT_WR_BYTE = 2'd2;
  localparam logic [1:0] ACT_WR_WORD = 2'd3;

  // address map
  localparam logic [11:0] CTRL_OFF = 12'h000;
  localparam logic [5:0]  KEY_PAGE = 6'h04;
  localparam logic [3:0]  EXP_PAGE = 4'h2;
  localparam logic [3:0]  MOD_PAGE = 4'h4;
  localparam logic [3:0]  TXT_PAGE = 4'h8;

  // key slot register codes
  localparam logic [1:0] KREG_STATUS = 2'd0;
  localparam logic [1:0] KREG_CAP    = 2'd1;
  localparam logic [DATA_W-1:0] KEY_CAP_VAL = 32'h0000_0040;

  // buffer targets
  localparam logic [1:0] TGT_TXT = 2'd0;
  localparam logic [1:0] TGT_EXP = 2'd1;
  localparam logic [1:0] TGT_MOD = 2'd2;

endpackage

FILE: rtl/rsa_modexp_engine_registers.sv
// ----------------------------------------------------------------------------
// rsa_modexp_engine_registers
// Register-mapped RSA modular exponentiation engine with byte-wide buffers
// and a bit-serial modular multiplier.
// ----------------------------------------------------------------------------
// Access: one at a time; a buffer access first wraps its byte index into range, one
//   step per wrap, then reads or writes its bytes one after another.
// Start: the operands are loaded byte by byte, then come the modular multiplies
//   (base reduction, a square per exponent bit from the top set bit on, a multiply
//   per set bit) as the exponent bits are scanned, then the result is written back.
// Reset: a clearing pass zeroes all buffers first.
module rsa_modexp_engine_registers
  import rme_pkg::*;
#(
  parameter int OPERAND_BYTES = 256,
  parameter int SLOT_COUNT    = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_TDATA_W-1:0] s_axis_tdata,  // offset[11:0], write_data[43:12], zero pad
  input  logic [1:0]            s_axis_tuser,  // action[1:0]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [DATA_W-1:0]     m_axis_tdata,  // read_data[31:0]
  output logic [0:0]            m_axis_tuser   // irq_raise[0]
);

  localparam int N     = 8 * OPERAND_BYTES;
  localparam int IW    = $clog2(OPERAND_BYTES);
  localparam int SW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int DEPTH = SLOT_COUNT * OPERAND_BYTES;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = ((IW > 8) ? IW : 8) + 1;
  localparam int CW    = $clog2(N) + 1;
  localparam int FW    = IW + 3;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DEC    = 4'd2;
  localparam logic [3:0] S_NORM   = 4'd3;
  localparam logic [3:0] S_BYTE   = 4'd4;
  localparam logic [3:0] S_BWAIT  = 4'd5;
  localparam logic [3:0] S_DONE   = 4'd6;
  localparam logic [3:0] S_XLD    = 4'd7;
  localparam logic [3:0] S_XLDC   = 4'd8;
  localparam logic [3:0] S_XCHK   = 4'd9;
  localparam logic [3:0] S_XBASE  = 4'd10;
  localparam logic [3:0] S_XSCAN  = 4'd11;
  localparam logic [3:0] S_XSQ    = 4'd12;
  localparam logic [3:0] S_XMULGO = 4'd13;
  localparam logic [3:0] S_XMUL   = 4'd14;
  localparam logic [3:0] S_WB     = 4'd15;

  // slot select reduced modulo the slot count
  function automatic logic [SW-1:0] slot_mod(input logic [1:0] s);
    logic [2:0] v;
    v = {1'b0, s};
    for (int n = 0; n < 3; n++) begin
      if (v >= 3'(SLOT_COUNT)) begin
        v = v - 3'(SLOT_COUNT);
      end
    end
    return SW'(v);
  endfunction

  logic [3:0]        state_q;
  logic [AW-1:0]     clr_q;
  logic [1:0]        act_q;
  logic [11:0]       off_q;
  logic [31:0]       wd_q;
  logic [1:0]        tgt_q;
  logic              mirror_q;
  logic [NW-1:0]     nidx_q;
  logic [IW-1:0]     pos_q;
  logic [1:0]        k_q;
  logic [DATA_W-1:0] rd_q;
  logic              irq_q;
  logic              out_valid_q;
  logic [DATA_W-1:0] out_data_q;
  logic              out_irq_q;
  logic [1:0]        slot_sel_q;
  logic              big_q;
  logic              fwd_q;
  logic [SLOT_COUNT-1:0] protect_q;
  logic [IW-1:0]     xfill_q [SLOT_COUNT];
  logic [IW-1:0]     mfill_q [SLOT_COUNT];
  logic [IW-1:0]     tfill_q;
  logic [N-1:0]      m_q;
  logic [N-1:0]      e_q;
  logic [N-1:0]      acc_q;
  logic [N-1:0]      base_q;
  logic              one_bit_q;
  logic              started_q;
  logic              ebit_q;
  logic [CW-1:0]     bcnt_q;

  logic [1:0]    kslot;
  logic [1:0]    kreg;
  logic          kslot_ok;
  logic          in_key;
  logic          in_exp;
  logic          in_mod;
  logic          in_txt;
  logic          is_ctrl;
  logic          memop;
  logic [SW-1:0] act_slot;
  logic [AW-1:0] slot_base;
  logic [IW-1:0] fsel;
  logic [FW-1:0] fadv;
  logic [IW-1:0] fnext;
  logic [NW-1:0] start_idx;
  logic [1:0]    lane;
  logic [7:0]    wbyte;
  logic [IW-1:0] pos_next;
  logic          last_byte;
  logic          pos_last;
  logic          clr_txt;
  logic          txt_we;
  logic [IW-1:0] txt_addr;
  logic [7:0]    txt_wdata;
  logic [7:0]    txt_rdata;
  logic          exp_we;
  logic          mod_we;
  logic [AW-1:0] key_addr;
  logic [7:0]    key_wdata;
  logic [7:0]    exp_rdata;
  logic [7:0]    mod_rdata;
  logic          m_zero;
  logic          m_one;
  logic          scan_go;
  logic          mm_start;
  logic [N-1:0]  mm_b;
  logic          mm_done;
  logic [N-1:0]  mm_r;

  // address decode
  assign kslot    = off_q[5:4];
  assign kreg     = off_q[3:2];
  assign kslot_ok = {1'b0, kslot} < 3'(SLOT_COUNT);
  assign in_key   = off_q[11:6] == KEY_PAGE;
  assign in_exp   = off_q[11:8] == EXP_PAGE;
  assign in_mod   = off_q[11:8] == MOD_PAGE;
  assign in_txt   = off_q[11:8] == TXT_PAGE;
  assign is_ctrl  = off_q == CTRL_OFF;
  assign memop    = (in_txt && !act_q[1]) || (act_q[1] && (in_exp || in_mod || in_txt));

  assign act_slot  = slot_mod(slot_sel_q);
  assign slot_base = AW'(act_slot) * AW'(OPERAND_BYTES);

  // fill counter of the addressed buffer and its advanced value
  assign fsel  = in_exp ? xfill_q[act_slot] : (in_mod ? mfill_q[act_slot] : tfill_q);
  assign fadv  = FW'(fsel) + (act_q[0] ? FW'(4) : FW'(1));
  assign fnext = (fadv >= FW'(OPERAND_BYTES)) ? '0 : fadv[IW-1:0];

  // first byte index of the access, mirrored in backward order except on the exponent buffer
  always_comb begin
    if (!mirror_q) begin
      start_idx = nidx_q;
    end else if (!act_q[0]) begin
      start_idx = NW'(OPERAND_BYTES - 1) - nidx_q;
    end else if (nidx_q + NW'(4) <= NW'(OPERAND_BYTES)) begin
      start_idx = NW'(OPERAND_BYTES - 4) - nidx_q;
    end else begin
      start_idx = NW'(2 * OPERAND_BYTES - 4) - nidx_q;
    end
  end

  // byte lane within the word
  assign lane      = (act_q[0] && !big_q) ? (2'd3 - k_q) : k_q;
  assign wbyte     = wd_q[{lane, 3'b000} +: 8];
  assign pos_last  = pos_q == IW'(OPERAND_BYTES - 1);
  assign pos_next  = pos_last ? '0 : pos_q + 1'b1;
  assign last_byte = !act_q[0] || (k_q == 2'd3);

  // buffer memory ports
  assign clr_txt   = {1'b0, clr_q} < (AW + 1)'(OPERAND_BYTES);
  assign txt_we    = ((state_q == S_CLEAR) && clr_txt) || (state_q == S_WB) ||
                     ((state_q == S_BYTE) && act_q[1] && (tgt_q == TGT_TXT));
  assign txt_addr  = (state_q == S_CLEAR) ? clr_q[IW-1:0] : pos_q;
  assign txt_wdata = (state_q == S_CLEAR) ? 8'h00 :
                     ((state_q == S_WB) ? acc_q[N-1 -: 8] : wbyte);
  assign exp_we    = (state_q == S_CLEAR) ||
                     ((state_q == S_BYTE) && act_q[1] && (tgt_q == TGT_EXP));
  assign mod_we    = (state_q == S_CLEAR) ||
                     ((state_q == S_BYTE) && act_q[1] && (tgt_q == TGT_MOD));
  assign key_addr  = (state_q == S_CLEAR) ? clr_q : slot_base + AW'(pos_q);
  assign key_wdata = (state_q == S_CLEAR) ? 8'h00 : wbyte;

  rme_ram #(.WIDTH(8), .DEPTH(OPERAND_BYTES)) u_txt_ram (
    .clk_i   (clk_i),
    .we_i    (txt_we),
    .waddr_i (txt_addr),
    .wdata_i (txt_wdata),
    .raddr_i (txt_addr),
    .rdata_o (txt_rdata)
  );

  rme_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_exp_ram (
    .clk_i   (clk_i),
    .we_i    (exp_we),
    .waddr_i (key_addr),
    .wdata_i (key_wdata),
    .raddr_i (key_addr),
    .rdata_o (exp_rdata)
  );

  rme_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_mod_ram (
    .clk_i   (clk_i),
    .we_i    (mod_we),
    .waddr_i (key_addr),
    .wdata_i (key_wdata),
    .raddr_i (key_addr),
    .rdata_o (mod_rdata)
  );

  // multiplier hookup
  assign m_zero   = m_q == '0;
  assign m_one    = m_q == N'(1);
  assign scan_go  = (bcnt_q != '0) && (started_q || e_q[N-1]);
  assign mm_start = ((state_q == S_XCHK) && !m_zero) ||
                    ((state_q == S_XSCAN) && scan_go) || (state_q == S_XMULGO);
  assign mm_b     = (state_q == S_XCHK) ? {{(N-1){1'b0}}, !m_one} :
                    ((state_q == S_XMULGO) ? base_q : acc_q);

  rme_mulmod #(.N(N)) u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mm_start),
    .a_i     (acc_q),
    .b_i     (mm_b),
    .m_i     (m_q),
    .done_o  (mm_done),
    .r_o     (mm_r)
  );

  // access sequencer and exponentiation control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      slot_sel_q  <= '0;
      big_q       <= 1'b0;
      fwd_q       <= 1'b0;
      protect_q   <= '0;
      tfill_q     <= '0;
      for (int s = 0; s < SLOT_COUNT; s++) begin
        xfill_q[s] <= '0;
        mfill_q[s] <= '0;
      end
    end else begin
      if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AW'(DEPTH - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            act_q   <= s_axis_tuser;
            off_q   <= s_axis_tdata[11:0];
            wd_q    <= s_axis_tdata[43:12];
            state_q <= S_DEC;
          end
        end
        S_DEC: begin
          rd_q    <= '0;
          irq_q   <= 1'b0;
          k_q     <= '0;
          state_q <= S_DONE;
          if (memop) begin
            tgt_q    <= in_exp ? TGT_EXP : (in_mod ? TGT_MOD : TGT_TXT);
            mirror_q <= !fwd_q && !in_exp;
            nidx_q   <= act_q[1] ? NW'(fsel) : NW'(off_q[7:0]);
            state_q  <= S_NORM;
            if (act_q[1]) begin
              if (in_exp) begin
                xfill_q[act_slot] <= fnext;
              end else if (in_mod) begin
                mfill_q[act_slot] <= fnext;
              end else begin
                tfill_q <= fnext;
              end
            end
          end else if (act_q == ACT_RD_WORD) begin
            if (in_key && kslot_ok && (kreg == KREG_STATUS)) begin
              rd_q <= {30'b0, protect_q[kslot[SW-1:0]], 1'b1};
            end else if (in_key && kslot_ok && (kreg == KREG_CAP)) begin
              rd_q <= KEY_CAP_VAL;
            end else if (is_ctrl) begin
              rd_q <= {22'b0, fwd_q, big_q, 2'b00, slot_sel_q, 4'b0000};
            end
          end else if (act_q == ACT_WR_WORD) begin
            if (in_key) begin
              if ((kreg == KREG_STATUS) && kslot_ok) begin
                protect_q[kslot[SW-1:0]] <= wd_q[1];
              end
            end else if (is_ctrl) begin
              slot_sel_q <= wd_q[5:4];
              big_q      <= wd_q[8];
              fwd_q      <= wd_q[9];
              if (wd_q[0]) begin
                irq_q   <= 1'b1;
                pos_q   <= '0;
                state_q <= S_XLD;
              end
            end
          end
        end
        S_NORM: begin
          if (nidx_q >= NW'(OPERAND_BYTES)) begin
            nidx_q <= nidx_q - NW'(OPERAND_BYTES);
          end else begin
            pos_q   <= start_idx[IW-1:0];
            state_q <= S_BYTE;
          end
        end
        S_BYTE: begin
          if (act_q[1]) begin
            pos_q   <= pos_next;
            k_q     <= k_q + 1'b1;
            state_q <= last_byte ? S_DONE : S_BYTE;
          end else begin
            state_q <= S_BWAIT;
          end
        end
        S_BWAIT: begin
          rd_q[{lane, 3'b000} +: 8] <= txt_rdata;
          pos_q   <= pos_next;
          k_q     <= k_q + 1'b1;
          state_q <= last_byte ? S_DONE : S_BYTE;
        end
        S_DONE: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_data_q  <= rd_q;
            out_irq_q   <= irq_q;
            state_q     <= S_IDLE;
          end
        end
        S_XLD: state_q <= S_XLDC;
        S_XLDC: begin
          // byte 0 is the most significant byte
          m_q     <= {m_q[N-9:0], mod_rdata};
          e_q     <= {e_q[N-9:0], exp_rdata};
          acc_q   <= {acc_q[N-9:0], txt_rdata};
          pos_q   <= pos_next;
          state_q <= pos_last ? S_XCHK : S_XLD;
        end
        S_XCHK: begin
          one_bit_q <= !m_one;
          if (m_zero) begin
            acc_q   <= '0;
            pos_q   <= '0;
            state_q <= S_WB;
          end else begin
            state_q <= S_XBASE;
          end
        end
        S_XBASE: begin
          if (mm_done) begin
            base_q    <= mm_r;
            acc_q     <= {{(N-1){1'b0}}, one_bit_q};
            bcnt_q    <= CW'(N);
            started_q <= 1'b0;
            state_q   <= S_XSCAN;
          end
        end
        S_XSCAN: begin
          if (bcnt_q == '0) begin
            pos_q   <= '0;
            state_q <= S_WB;
          end else begin
            e_q    <= {e_q[N-2:0], 1'b0};
            bcnt_q <= bcnt_q - 1'b1;
            if (scan_go) begin
              started_q <= 1'b1;
              ebit_q    <= e_q[N-1];
              state_q   <= S_XSQ;
            end
          end
        end
        S_XSQ: begin
          if (mm_done) begin
            acc_q   <= mm_r;
            state_q <= ebit_q ? S_XMULGO : S_XSCAN;
          end
        end
        S_XMULGO: state_q <= S_XMUL;
        S_XMUL: begin
          if (mm_done) begin
            acc_q   <= mm_r;
            state_q <= S_XSCAN;
          end
        end
        S_WB: begin
          acc_q   <= {acc_q[N-9:0], 8'h00};
          pos_q   <= pos_next;
          state_q <= pos_last ? S_DONE : S_WB;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = state_q == S_IDLE;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_irq_q;

endmodule

FILE: rtl/rme_ram.sv
// ----------------------------------------------------------------------------
// rme_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rme_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/rme_mulmod.sv
// ----------------------------------------------------------------------------
// rme_mulmod
// Bit-serial interleaved modular multiplier: r = a * b mod m, one bit of a
// per iteration (a double-and-add and two conditional subtractions). Needs b < m.
// ----------------------------------------------------------------------------
module rme_mulmod #(
  parameter int N = 2048
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [N-1:0] a_i,
  input  logic [N-1:0] b_i,
  input  logic [N-1:0] m_i,
  output logic         done_o,
  output logic [N-1:0] r_o
);

  localparam int CW = $clog2(N) + 1;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_ADD  = 2'd1;
  localparam logic [1:0] PH_SUB1 = 2'd2;
  localparam logic [1:0] PH_SUB2 = 2'd3;

  logic [1:0]    phase_q;
  logic [CW-1:0] cnt_q;
  logic          done_q;
  logic [N-1:0]  a_q;
  logic [N-1:0]  b_q;
  logic [N-1:0]  r_q;
  logic [N+1:0]  t_q;
  logic [N+1:0]  m_ext;
  logic [N+1:0]  t_sub;
  logic          t_ge;

  // shared compare and subtract
  assign m_ext = {2'b00, m_i};
  assign t_ge  = t_q >= m_ext;
  assign t_sub = t_q - m_ext;

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (phase_q)
        PH_IDLE: begin
          if (start_i) begin
            phase_q <= PH_ADD;
            cnt_q   <= CW'(N);
          end
        end
        PH_ADD:  phase_q <= PH_SUB1;
        PH_SUB1: phase_q <= PH_SUB2;
        PH_SUB2: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CW'(1)) begin
            phase_q <= PH_IDLE;
            done_q  <= 1'b1;
          end else begin
            phase_q <= PH_ADD;
          end
        end
        default: phase_q <= PH_IDLE;
      endcase
    end
  end

  // datapath: multiplier bits leave a_q msb first
  always_ff @(posedge clk_i) begin
    case (phase_q)
      PH_IDLE: begin
        if (start_i) begin
          a_q <= a_i;
          b_q <= b_i;
          r_q <= '0;
        end
      end
      PH_ADD: begin
        t_q <= {1'b0, r_q, 1'b0} + (a_q[N-1] ? {2'b00, b_q} : '0);
        a_q <= {a_q[N-2:0], 1'b0};
      end
      PH_SUB1: begin
        if (t_ge) begin
          t_q <= t_sub;
        end
      end
      PH_SUB2: begin
        r_q <= t_ge ? t_sub[N-1:0] : t_q[N-1:0];
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign r_o    = r_q;

endmodule

FILE: rtl/rme_checker.sv
// ----------------------------------------------------------------------------
// rme_checker
// Port-level checks of the modular exponentiation engine, bound to the top.
// ----------------------------------------------------------------------------
module rme_checker
  import rme_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [DATA_W-1:0] m_axis_tdata,
  input logic [0:0]        m_axis_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // an exponentiation start is a write, so no read data comes with it
  a_irq_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("interrupt transfer carries read data");

  // one access at a time: input closes right after a transfer
  a_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second access taken while busy");

  // no result and no input accepted during reset
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid && !s_axis_tready)
    else $error("activity during reset");

endmodule

bind rsa_modexp_engine_registers rme_checker u_rme_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

FILE: dv/rsa_modexp_engine_registers_tb.sv
// ----------------------------------------------------------------------------
// rsa_modexp_engine_registers_tb
// Self-checking bench for the register-mapped RSA engine. Bus accesses go in
// on the slave stream and every response is compared with a scoreboard fed by
// an in-bench model of the register map, the fill counters and the modular
// exponentiation. A directed table comes first, then random register traffic
// mixed with full key loads that end in short exponentiations.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rsa_modexp_engine_registers_tb;
  import rme_pkg::*;

  localparam int NBYTES     = 256;
  localparam int NSLOTS     = 4;
  localparam int IDLE_LIMIT = 200000;

  typedef struct packed {
    logic [DATA_W-1:0] rd;
    logic              irq;
  } resp_t;

  typedef struct {
    logic [1:0]        act;
    logic [11:0]       off;
    logic [DATA_W-1:0] wd;
    bit                typed;
    logic [DATA_W-1:0] rd;
    logic              irq;
  } row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic [1:0]            s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [DATA_W-1:0]     m_axis_tdata;
  logic [0:0]            m_axis_tuser;

  // engine state as the bench sees it
  logic [1:0] sel_slot;
  logic       ord_big;
  logic       ord_fwd;
  logic [7:0] text_mem [NBYTES];
  logic [7:0] exp_mem  [NSLOTS][NBYTES];
  logic [7:0] mod_mem  [NSLOTS][NBYTES];
  int         text_fill;
  int         exp_fill [NSLOTS];
  int         mod_fill [NSLOTS];
  logic       protect  [NSLOTS];

  resp_t resp_q[$];
  int    errors = 0;
  int    n_items = 0;
  int    n_resp = 0;
  int    n_starts = 0;
  int    burst_left = 0;
  int    idle_cnt = 0;
  int    rdy_cyc = 0;

  rsa_modexp_engine_registers DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [7:0] mirror1(input logic [7:0] i);
    return 8'(8'd255 - i);
  endfunction

  function automatic logic [7:0] mirror4(input logic [7:0] i);
    return 8'(8'd252 - i);
  endfunction

  function automatic int step_fill(input int f, input int stp);
    return (f + stp >= NBYTES) ? 0 : f + stp;
  endfunction

  function automatic logic [31:0] bswap(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  // store a word into a buffer, ascending byte indexes with wrap
  function automatic void store_word(input logic [1:0] tgt, input logic [7:0] idx,
                                     input logic [31:0] v);
    logic [31:0] w;
    logic [7:0]  p;
    w = ord_big ? v : bswap(v);
    for (int k = 0; k < 4; k++) begin
      p = 8'(idx + k);
      case (tgt)
        TGT_TXT: text_mem[p] = w[8*k +: 8];
        TGT_EXP: exp_mem[sel_slot][p] = w[8*k +: 8];
        default: mod_mem[sel_slot][p] = w[8*k +: 8];
      endcase
    end
  endfunction

  function automatic logic [31:0] load_text_word(input logic [7:0] idx);
    logic [31:0] w;
    for (int k = 0; k < 4; k++) w[8*k +: 8] = text_mem[8'(idx + k)];
    return ord_big ? w : bswap(w);
  endfunction

  // text = text^exponent mod modulus, all big-endian byte strings
  function automatic void modexp_text();
    logic [2047:0] m, e, t, acc, base;
    logic [4095:0] prod;
    bit            started;
    started = 0;
    for (int p = 0; p < NBYTES; p++) begin
      m[(255-p)*8 +: 8] = mod_mem[sel_slot][p];
      e[(255-p)*8 +: 8] = exp_mem[sel_slot][p];
      t[(255-p)*8 +: 8] = text_mem[p];
    end
    if (m == '0) begin
      for (int p = 0; p < NBYTES; p++) text_mem[p] = 8'h00;
      return;
    end
    base = t % m;
    acc  = (m == 2048'd1) ? '0 : 2048'd1;
    for (int b = 2047; b >= 0; b--) begin
      if (!started && !e[b]) continue;
      started = 1;
      prod = {2048'b0, acc} * {2048'b0, acc};
      acc  = 2048'(prod % {2048'b0, m});
      if (e[b]) begin
        prod = {2048'b0, acc} * {2048'b0, base};
        acc  = 2048'(prod % {2048'b0, m});
      end
    end
    for (int p = 0; p < NBYTES; p++) text_mem[p] = acc[(255-p)*8 +: 8];
  endfunction

  // one bus access applied to the state, returns the response
  function automatic resp_t access_result(input logic [1:0] act, input logic [11:0] off,
                                          input logic [31:0] wd);
    resp_t      r;
    logic [7:0] i;
    logic [1:0] kslot, kreg;
    bit         in_key, in_exp, in_mod, in_txt;
    r      = '0;
    i      = off[7:0];
    kslot  = off[5:4];
    kreg   = off[3:2];
    in_key = off[11:6] == KEY_PAGE;
    in_exp = off[11:8] == EXP_PAGE;
    in_mod = off[11:8] == MOD_PAGE;
    in_txt = off[11:8] == TXT_PAGE;
    case (act)
      ACT_RD_BYTE: begin
        if (in_txt) r.rd = {24'b0, text_mem[ord_fwd ? i : mirror1(i)]};
      end
      ACT_RD_WORD: begin
        if (in_key) begin
          if (kreg == KREG_STATUS) r.rd = {30'b0, protect[kslot], 1'b1};
          else if (kreg == KREG_CAP) r.rd = KEY_CAP_VAL;
        end else if (in_txt) begin
          r.rd = load_text_word(ord_fwd ? i : mirror4(i));
        end else if (off == CTRL_OFF) begin
          r.rd = {22'b0, ord_fwd, ord_big, 2'b0, sel_slot, 4'b0};
        end
      end
      ACT_WR_BYTE: begin
        if (in_exp) begin
          exp_mem[sel_slot][exp_fill[sel_slot]] = wd[7:0];
          exp_fill[sel_slot] = step_fill(exp_fill[sel_slot], 1);
        end else if (in_mod) begin
          mod_mem[sel_slot][ord_fwd ? 8'(mod_fill[sel_slot]) : mirror1(8'(mod_fill[sel_slot]))]
            = wd[7:0];
          mod_fill[sel_slot] = step_fill(mod_fill[sel_slot], 1);
        end else if (in_txt) begin
          text_mem[ord_fwd ? 8'(text_fill) : mirror1(8'(text_fill))] = wd[7:0];
          text_fill = step_fill(text_fill, 1);
        end
      end
      default: begin
        if (in_key && kreg == KREG_STATUS) begin
          protect[kslot] = wd[1];
        end else if (in_exp) begin
          store_word(TGT_EXP, 8'(exp_fill[sel_slot]), wd);
          exp_fill[sel_slot] = step_fill(exp_fill[sel_slot], 4);
        end else if (in_mod) begin
          store_word(TGT_MOD, ord_fwd ? 8'(mod_fill[sel_slot])
                                      : mirror4(8'(mod_fill[sel_slot])), wd);
          mod_fill[sel_slot] = step_fill(mod_fill[sel_slot], 4);
        end else if (in_txt) begin
          store_word(TGT_TXT, ord_fwd ? 8'(text_fill) : mirror4(8'(text_fill)), wd);
          text_fill = step_fill(text_fill, 4);
        end else if (off == CTRL_OFF) begin
          sel_slot = wd[5:4];
          ord_big  = wd[8];
          ord_fwd  = wd[9];
          if (wd[0]) begin
            modexp_text();
            r.irq = 1'b1;
          end
        end
      end
    endcase
    return r;
  endfunction

  // drive one access, wait for the transfer, then queue its expected response
  task automatic send(input logic [1:0] act, input logic [11:0] off, input logic [31:0] wd,
                      input bit typed = 0, input logic [31:0] t_rd = '0,
                      input logic t_irq = 1'b0);
    resp_t r;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, wd, off};
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!s_axis_tready);
    r = access_result(act, off, wd);
    if (typed) r = '{rd: t_rd, irq: t_irq};
    resp_q.push_back(r);
    n_items++;
    if (r.irq) n_starts++;
    // bursts with random gaps between them
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      if ($urandom_range(0, 3) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end
    end
  endtask

  // random register traffic, start bit always clear
  task automatic random_access();
    logic [1:0]  act;
    logic [11:0] off;
    logic [31:0] wd;
    act = 2'($urandom_range(0, 3));
    wd  = $urandom;
    case ($urandom_range(0, 9))
      0:       off = CTRL_OFF;
      1:       off = {KEY_PAGE, 6'($urandom_range(0, 63))};
      2:       off = {EXP_PAGE, 8'($urandom_range(0, 255))};
      3:       off = {MOD_PAGE, 8'($urandom_range(0, 255))};
      4, 5, 6: off = {TXT_PAGE, 8'($urandom_range(0, 255))};
      default: off = 12'($urandom_range(0, 4095));
    endcase
    if (off == CTRL_OFF && act == ACT_WR_WORD) wd[0] = 1'b0;
    send(act, off, wd);
  endtask

  // load a slot with a small exponent, fresh modulus and text, start, then read text words
  task automatic key_start(input logic [1:0] slot, input logic [31:0] expo,
                           input bit sparse_mod);
    logic [31:0] ctl;
    logic [31:0] w;
    int          f;
    ctl = {22'b0, 1'($urandom_range(0, 1)), 1'b0, 2'b0, slot, 4'b0};
    send(ACT_WR_WORD, CTRL_OFF, ctl);
    while (exp_fill[slot] % 4 != 0) send(ACT_WR_BYTE, {EXP_PAGE, 8'($urandom)}, 32'h0);
    f = exp_fill[slot];
    // the word landing on the last four bytes carries the exponent
    repeat (64) begin
      send(ACT_WR_WORD, {EXP_PAGE, 8'($urandom)}, (f == NBYTES - 4) ? expo : 32'h0);
      f = step_fill(f, 4);
    end
    while (mod_fill[slot] % 4 != 0) send(ACT_WR_BYTE, {MOD_PAGE, 8'($urandom)}, $urandom);
    repeat (64) begin
      w = $urandom;
      if (sparse_mod && $urandom_range(0, 9) != 0) w = '0;
      send(ACT_WR_WORD, {MOD_PAGE, 8'($urandom)}, w);
    end
    while (text_fill % 4 != 0) send(ACT_WR_BYTE, {TXT_PAGE, 8'($urandom)}, $urandom);
    repeat (64) send(ACT_WR_WORD, {TXT_PAGE, 8'($urandom)}, $urandom);
    send(ACT_WR_WORD, CTRL_OFF, ctl | 32'h1);
    repeat (8) send(ACT_RD_WORD, {TXT_PAGE, 8'($urandom)}, $urandom);
  endtask

  // receiver stall pattern: phases of no stall, light and heavy stalling
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rdy_cyc       <= 0;
    end else begin
      rdy_cyc <= rdy_cyc + 1;
      case ((rdy_cyc / 317) % 3)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= ($urandom_range(0, 9) < 7);
        default: m_axis_tready <= ($urandom_range(0, 9) < 3);
      endcase
    end
  end

  // response scoreboard
  always @(posedge clk_i) begin
    resp_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_resp++;
      if (resp_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected response rd=%h irq=%b", $time, m_axis_tdata, m_axis_tuser);
      end else begin
        exp_r = resp_q.pop_front();
        if (m_axis_tdata !== exp_r.rd) begin
          errors++;
          $display("%0t: read_data expected %h actual %h", $time, exp_r.rd, m_axis_tdata);
        end
        if (m_axis_tuser[0] !== exp_r.irq) begin
          errors++;
          $display("%0t: irq_raise expected %b actual %b", $time, exp_r.irq, m_axis_tuser[0]);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, idle_cnt);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  initial begin
    row_t rows[$];
    // falling reset edge at time zero
    rst_ni    <= 1'b0;
    sel_slot  = '0;
    ord_big   = 1'b0;
    ord_fwd   = 1'b0;
    text_fill = 0;
    for (int p = 0; p < NBYTES; p++) text_mem[p] = 8'h00;
    for (int s = 0; s < NSLOTS; s++) begin
      exp_fill[s] = 0;
      mod_fill[s] = 0;
      protect[s]  = 1'b0;
      for (int p = 0; p < NBYTES; p++) begin
        exp_mem[s][p] = 8'h00;
        mod_mem[s][p] = 8'h00;
      end
    end

    // directed accesses: reset values, key registers, unmapped offsets, orders, zero modulus
    rows = '{
      '{ACT_RD_WORD, CTRL_OFF, 32'h0,          1, 32'h0,       1'b0},
      '{ACT_RD_WORD, 12'h100,  32'h0,          1, 32'h1,       1'b0},
      '{ACT_RD_WORD, 12'h104,  32'h0,          1, KEY_CAP_VAL, 1'b0},
      '{ACT_RD_WORD, 12'h108,  32'h0,          1, 32'h0,       1'b0},
      '{ACT_RD_WORD, 12'h13C,  32'h0,          1, 32'h0,       1'b0},
      '{ACT_RD_BYTE, CTRL_OFF, 32'h0,          1, 32'h0,       1'b0},
      '{ACT_RD_BYTE, 12'h104,  32'h0,          1, 32'h0,       1'b0},
      '{ACT_RD_WORD, 12'hFFC,  32'h0,          1, 32'h0,       1'b0},
      '{ACT_WR_WORD, 12'h130,  32'hFFFF_FFFF,  1, 32'h0,       1'b0},
      '{ACT_RD_WORD, 12'h130,  32'h0,          1, 32'h3,       1'b0},
      '{ACT_WR_WORD, CTRL_OFF, 32'hFFFF_FFF0,  1, 32'h0,       1'b0},
      '{ACT_RD_WORD, CTRL_OFF, 32'h0,          1, 32'h330,     1'b0},
      '{ACT_WR_WORD, 12'h800,  32'h1122_3344,  0, 32'h0,       1'b0},
      '{ACT_RD_WORD, 12'h800,  32'h0,          0, 32'h0,       1'b0},
      '{ACT_WR_BYTE, 12'h8FF,  32'hFFFF_FFAB,  0, 32'h0,       1'b0},
      '{ACT_RD_BYTE, 12'h801,  32'h0,          0, 32'h0,       1'b0},
      '{ACT_WR_WORD, CTRL_OFF, 32'h0,          1, 32'h0,       1'b0},
      '{ACT_RD_WORD, 12'h8FE,  32'h0,          0, 32'h0,       1'b0},
      '{ACT_RD_BYTE, 12'h8FF,  32'h0,          0, 32'h0,       1'b0},
      '{ACT_WR_WORD, CTRL_OFF, 32'h1,          1, 32'h0,       1'b1},
      '{ACT_RD_WORD, 12'h800,  32'h0,          1, 32'h0,       1'b0},
      '{ACT_WR_BYTE, 12'h2FF,  32'h0000_00FF,  0, 32'h0,       1'b0},
      '{ACT_WR_WORD, 12'h4FC,  32'hFFFF_FFFF,  0, 32'h0,       1'b0},
      '{ACT_RD_WORD, 12'h8FD,  32'h0,          0, 32'h0,       1'b0}
    };

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[n])
      send(rows[n].act, rows[n].off, rows[n].wd, rows[n].typed, rows[n].rd, rows[n].irq);

    // random traffic interleaved with key loads and starts
    for (int k = 0; k < 4; k++) begin
      repeat (130) random_access();
      case (k)
        0:       key_start(2'd1, 32'd3, 0);
        1:       key_start(2'd2, 32'd1, 1);
        2:       key_start(2'd3, 32'd17, 0);
        default: key_start(2'd0, 32'd5, 1);
      endcase
    end
    s_axis_tvalid <= 1'b0;

    while (resp_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("covered %0d accesses, %0d responses, %0d exponentiations", n_items, n_resp,
             n_starts);
    $display("all slots, both byte and word orders, key registers and unmapped offsets hit");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/rme_pkg.sv
rtl/rme_ram.sv
rtl/rme_mulmod.sv
rtl/rsa_modexp_engine_registers.sv
rtl/rme_checker.sv
dv/rsa_modexp_engine_registers_tb.sv
